FILE: rtl/pgmr_pkg.sv
// Shared types and constants for the 16-bit binary PGM stream reader.
package pgmr_pkg;

   localparam int DIM_BITS_DEFAULT = 16;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [2:0] ERR_NOT_P5      = 3'd0;
   localparam logic [2:0] ERR_TRUNCATED   = 3'd1;
   localparam logic [2:0] ERR_INVALID     = 3'd2;
   localparam logic [2:0] ERR_EIGHT_BIT   = 3'd3;
   localparam logic [2:0] ERR_SHORT_DATA  = 3'd4;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_FIVE  = 8'h35;
   localparam logic [7:0] CH_P     = 8'h50;

   localparam logic [1:0] MAGIC_NONE = 2'd0;
   localparam logic [1:0] MAGIC_P    = 2'd1;
   localparam logic [1:0] MAGIC_P5   = 2'd2;
   localparam logic [1:0] MAGIC_BAD  = 2'd3;

   localparam logic [1:0] TOK_MAGIC  = 2'd0;
   localparam logic [1:0] TOK_WIDTH  = 2'd1;
   localparam logic [1:0] TOK_HEIGHT = 2'd2;
   localparam logic [1:0] TOK_MAXVAL = 2'd3;

   localparam int SAMPLE_MAX    = 65535;
   localparam int EIGHT_BIT_MAX = 255;

   typedef struct packed {
      logic        fail;
      logic        accept;
      logic [2:0]  code;
      logic [15:0] width;
      logic [15:0] height;
      logic [15:0] maxval;
   } hdr_res_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] value;
      logic        last;
   } pix_res_type;

endpackage

FILE: rtl/pgmr_header.sv
// Header tokenizer: magic check, number parsing and header validation.
module pgmr_header
   import pgmr_pkg::*;
#(
   parameter int DIM_BITS = DIM_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    first,
   input  logic                    eof,
   input  logic [7:0]              byte_value,
   output hdr_res_type             res,
   output logic [2*DIM_BITS-1:0]   image_pixels
);

   localparam int AccBits = (DIM_BITS > 16) ? DIM_BITS : 16;
   localparam int AccW    = AccBits + 1;
   localparam int MulW    = AccW + 4;
   localparam logic [AccW-1:0] AccLimit = AccW'(1 << AccBits);
   localparam logic [AccW-1:0] DimMax   = AccW'((1 << DIM_BITS) - 1);

   logic [1:0]          token_number_ff, token_number_in, cur_token_number;
   logic                token_started_ff, token_started_in, cur_token_started;
   logic                in_comment_ff, in_comment_in, cur_in_comment;
   logic [1:0]          magic_ff, magic_in, cur_magic;
   logic                negative_ff, negative_in, cur_negative;
   logic                stopped_ff, stopped_in, cur_stopped;
   logic [AccW-1:0]     accum_ff, accum_in, cur_accum;
   logic [DIM_BITS-1:0] width_ff, width_in, cur_width;
   logic [DIM_BITS-1:0] height_ff, height_in, cur_height;

   logic                is_space;
   logic                is_digit;
   logic [3:0]          digit;
   logic [MulW-1:0]     acc_mul;
   logic [AccW-1:0]     acc_next;
   logic [DIM_BITS-1:0] dim_value;
   logic                max_ok;
   logic [15:0]         maxval_sat;
   logic                chk_fail;
   logic [2:0]          chk_code;

   assign cur_token_number  = first ? TOK_MAGIC : token_number_ff;
   assign cur_token_started = first ? 1'b0 : token_started_ff;
   assign cur_in_comment    = first ? 1'b0 : in_comment_ff;
   assign cur_magic         = first ? MAGIC_NONE : magic_ff;
   assign cur_negative      = first ? 1'b0 : negative_ff;
   assign cur_stopped       = first ? 1'b0 : stopped_ff;
   assign cur_accum         = first ? '0 : accum_ff;
   assign cur_width         = first ? '0 : width_ff;
   assign cur_height        = first ? '0 : height_ff;

   assign is_space = (byte_value == CH_SPACE) ||
                     ((byte_value >= CH_TAB) && (byte_value <= CH_CR));
   assign is_digit = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
   assign digit    = 4'(byte_value - CH_ZERO);
   assign acc_mul  = (MulW'(cur_accum) << 3) + (MulW'(cur_accum) << 1) + MulW'(digit);
   assign acc_next = (acc_mul > MulW'(AccLimit)) ? AccLimit : acc_mul[AccW-1:0];

   assign dim_value = (cur_negative || (cur_accum == '0) || (cur_accum > DimMax)) ?
                      '0 : cur_accum[DIM_BITS-1:0];

   assign max_ok     = !cur_negative && (cur_accum != '0);
   assign maxval_sat = (cur_accum > AccW'(SAMPLE_MAX)) ? 16'hFFFF : cur_accum[15:0];

   always_comb begin
      chk_fail = 1'b0;
      chk_code = ERR_INVALID;
      if ((cur_width == '0) || (cur_height == '0) || !max_ok) begin
         chk_fail = 1'b1;
      end else if (maxval_sat <= 16'(EIGHT_BIT_MAX)) begin
         chk_fail = 1'b1;
         chk_code = ERR_EIGHT_BIT;
      end
   end

   assign image_pixels = (2*DIM_BITS)'(cur_width) * (2*DIM_BITS)'(cur_height);

   always_comb begin
      token_number_in  = cur_token_number;
      token_started_in = cur_token_started;
      in_comment_in    = cur_in_comment;
      magic_in         = cur_magic;
      negative_in      = cur_negative;
      stopped_in       = cur_stopped;
      accum_in         = cur_accum;
      width_in         = cur_width;
      height_in        = cur_height;
      res              = '0;
      if (step) begin
         if (eof) begin
            res.fail = 1'b1;
            if (cur_token_number == TOK_MAGIC) begin
               res.code = (cur_magic == MAGIC_P5) ? ERR_TRUNCATED : ERR_NOT_P5;
            end else if ((cur_token_number != TOK_MAXVAL) || !cur_token_started) begin
               res.code = ERR_TRUNCATED;
            end else begin
               res.code = chk_fail ? chk_code : ERR_SHORT_DATA;
            end
         end else if (cur_in_comment) begin
            if (byte_value == CH_LF) begin
               in_comment_in = 1'b0;
            end
         end else if (byte_value == CH_HASH) begin
            in_comment_in = 1'b1;
         end else if (is_space) begin
            if (cur_token_started) begin
               token_started_in = 1'b0;
               magic_in         = MAGIC_NONE;
               negative_in      = 1'b0;
               stopped_in       = 1'b0;
               accum_in         = '0;
               case (cur_token_number)
                  TOK_MAGIC: begin
                     if (cur_magic != MAGIC_P5) begin
                        res.fail = 1'b1;
                        res.code = ERR_NOT_P5;
                     end
                     token_number_in = TOK_WIDTH;
                  end
                  TOK_WIDTH: begin
                     width_in        = dim_value;
                     token_number_in = TOK_HEIGHT;
                  end
                  TOK_HEIGHT: begin
                     height_in       = dim_value;
                     token_number_in = TOK_MAXVAL;
                  end
                  default: begin
                     if (chk_fail) begin
                        res.fail = 1'b1;
                        res.code = chk_code;
                     end else begin
                        res.accept = 1'b1;
                        res.width  = 16'(cur_width);
                        res.height = 16'(cur_height);
                        res.maxval = maxval_sat;
                     end
                  end
               endcase
            end
         end else begin
            if (cur_token_number == TOK_MAGIC) begin
               case (cur_magic)
                  MAGIC_NONE: magic_in = (byte_value == CH_P) ? MAGIC_P : MAGIC_BAD;
                  MAGIC_P:    magic_in = (byte_value == CH_FIVE) ? MAGIC_P5 : MAGIC_BAD;
                  default:    magic_in = MAGIC_BAD;
               endcase
            end else if (!cur_token_started &&
                         ((byte_value == CH_PLUS) || (byte_value == CH_MINUS))) begin
               negative_in = (byte_value == CH_MINUS);
            end else if (!cur_stopped && is_digit) begin
               accum_in = acc_next;
            end else begin
               stopped_in = 1'b1;
            end
            token_started_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_number_ff  <= TOK_MAGIC;
         token_started_ff <= 1'b0;
         in_comment_ff    <= 1'b0;
         magic_ff         <= MAGIC_NONE;
         negative_ff      <= 1'b0;
         stopped_ff       <= 1'b0;
         accum_ff         <= '0;
         width_ff         <= '0;
         height_ff        <= '0;
      end else if (step) begin
         token_number_ff  <= token_number_in;
         token_started_ff <= token_started_in;
         in_comment_ff    <= in_comment_in;
         magic_ff         <= magic_in;
         negative_ff      <= negative_in;
         stopped_ff       <= stopped_in;
         accum_ff         <= accum_in;
         width_ff         <= width_in;
         height_ff        <= height_in;
      end
   end

endmodule

FILE: rtl/pgmr_pixel.sv
// Pixel assembler: pairs bytes into big-endian samples and counts down the image.
module pgmr_pixel
   import pgmr_pkg::*;
#(
   parameter int DIM_BITS = DIM_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [2*DIM_BITS-1:0] image_pixels,
   input  logic                  step,
   input  logic [7:0]            byte_value,
   output pix_res_type           res
);

   logic [2*DIM_BITS-1:0] left_ff;
   logic [7:0]            high_ff;
   logic                  have_ff;

   assign res.valid = step && have_ff;
   assign res.value = {high_ff, byte_value};
   assign res.last  = (left_ff == (2*DIM_BITS)'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         have_ff <= 1'b0;
      end else if (load) begin
         left_ff <= image_pixels;
         have_ff <= 1'b0;
      end else if (step) begin
         if (have_ff) begin
            have_ff <= 1'b0;
            left_ff <= left_ff - (2*DIM_BITS)'(1);
         end else begin
            have_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && !have_ff) begin
         high_ff <= byte_value;
      end
   end

endmodule

FILE: rtl/pgm16_stream_reader.sv
// Top level of the 16-bit binary PGM stream reader.
// Takes one file byte (or an end-of-file marker) per transaction and returns at most one
// result per transaction: a header result after the whitespace that ends maxval, one pixel
// result for every second data byte, or one error. An item passes an input register, the
// combinational parsing logic and a result register, and a new one can be accepted on every
// cycle; throughput is one byte per clock, limited only by rsp_stall. Start every file with
// req_first_byte set; after an error or the final pixel, items are dropped until the next
// first byte.
module pgm16_stream_reader
   import pgmr_pkg::*;
#(
   parameter int DIM_BITS = DIM_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic        req_first_byte,
   input  logic [7:0]  req_byte_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_error_code,
   output logic [15:0] rsp_image_width,
   output logic [15:0] rsp_image_height,
   output logic [15:0] rsp_max_sample,
   output logic [15:0] rsp_pixel_value,
   output logic        rsp_last_pixel
);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PIXELS,
      PH_DONE
   } phase_type;

   phase_type   phase_ff, phase_in, phase_cur;

   logic        in_valid_ff;
   logic        in_mode_ff;
   logic        in_first_ff;
   logic [7:0]  in_byte_ff;

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_kind_ff, out_kind_in;
   logic [2:0]  out_code_ff, out_code_in;
   logic [15:0] out_width_ff, out_width_in;
   logic [15:0] out_height_ff, out_height_in;
   logic [15:0] out_maxval_ff, out_maxval_in;
   logic [15:0] out_pixel_ff, out_pixel_in;
   logic        out_last_ff, out_last_in;

   logic        can_load;
   logic        fire;
   logic        accept;
   logic        hdr_step;
   logic        pix_step;

   hdr_res_type           hdr_res;
   pix_res_type           pix_res;
   logic [2*DIM_BITS-1:0] image_pixels;

   assign can_load  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && can_load;
   assign req_stall = in_valid_ff && !can_load;
   assign accept    = req_valid && !req_stall;

   assign phase_cur = in_first_ff ? PH_HEADER : phase_ff;
   assign hdr_step  = fire && (phase_cur == PH_HEADER);
   assign pix_step  = fire && (phase_cur == PH_PIXELS) && !in_mode_ff;

   pgmr_header #(
      .DIM_BITS (DIM_BITS)
   ) u_header (
      .clock        (clock),
      .reset        (reset),
      .step         (hdr_step),
      .first        (in_first_ff),
      .eof          (in_mode_ff),
      .byte_value   (in_byte_ff),
      .res          (hdr_res),
      .image_pixels (image_pixels)
   );

   pgmr_pixel #(
      .DIM_BITS (DIM_BITS)
   ) u_pixel (
      .clock        (clock),
      .reset        (reset),
      .load         (hdr_res.accept),
      .image_pixels (image_pixels),
      .step         (pix_step),
      .byte_value   (in_byte_ff),
      .res          (pix_res)
   );

   always_comb begin
      phase_in      = phase_cur;
      out_valid_in  = 1'b0;
      out_kind_in   = KIND_ERROR;
      out_code_in   = ERR_NOT_P5;
      out_width_in  = '0;
      out_height_in = '0;
      out_maxval_in = '0;
      out_pixel_in  = '0;
      out_last_in   = 1'b0;
      case (phase_cur)
         PH_HEADER: begin
            if (hdr_res.fail) begin
               out_valid_in = 1'b1;
               out_code_in  = hdr_res.code;
               phase_in     = PH_DONE;
            end else if (hdr_res.accept) begin
               out_valid_in  = 1'b1;
               out_kind_in   = KIND_HEADER;
               out_width_in  = hdr_res.width;
               out_height_in = hdr_res.height;
               out_maxval_in = hdr_res.maxval;
               phase_in      = PH_PIXELS;
            end
         end
         PH_PIXELS: begin
            if (in_mode_ff) begin
               out_valid_in = 1'b1;
               out_code_in  = ERR_SHORT_DATA;
               phase_in     = PH_DONE;
            end else if (pix_res.valid) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_PIXEL;
               out_pixel_in = pix_res.value;
               out_last_in  = pix_res.last;
               if (pix_res.last) begin
                  phase_in = PH_DONE;
               end
            end
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         if (fire) begin
            phase_ff     <= phase_in;
            out_valid_ff <= out_valid_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         in_mode_ff  <= req_mode;
         in_first_ff <= req_first_byte;
         in_byte_ff  <= req_byte_value;
      end
      if (fire) begin
         out_kind_ff   <= out_kind_in;
         out_code_ff   <= out_code_in;
         out_width_ff  <= out_width_in;
         out_height_ff <= out_height_in;
         out_maxval_ff <= out_maxval_in;
         out_pixel_ff  <= out_pixel_in;
         out_last_ff   <= out_last_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_error_code   = (out_kind_ff == KIND_ERROR) ? out_code_ff : ERR_NOT_P5;
   assign rsp_image_width  = out_width_ff;
   assign rsp_image_height = out_height_ff;
   assign rsp_max_sample   = out_maxval_ff;
   assign rsp_pixel_value  = out_pixel_ff;
   assign rsp_last_pixel   = out_last_ff;

endmodule
